### sv/dtsc_pkg.sv
// ----------------------------------------------------------------------------
// dtsc_pkg
// Shared widths, reset values and codes for the dynamic threshold step counter.
// ----------------------------------------------------------------------------
package dtsc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TOTAL_BITS  = 32;

  // extreme registers must hold the +/-100.0 window reset values
  localparam int EXT_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int STEP_W = 15;
  localparam int THR_W  = 14;
  localparam int CNT_W  = 8;
  localparam int CMP_W  = (SAMPLE_BITS + 1 > STEP_W) ? SAMPLE_BITS + 1 : STEP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;
  localparam int NAXES = 3;

  localparam logic signed [EXT_W-1:0] PEAK_RESET   = EXT_W'(-25600);
  localparam logic signed [EXT_W-1:0] VALLEY_RESET = EXT_W'(25600);
  localparam logic [CNT_W-1:0]        CNT_MAX      = '1;

  localparam logic [STEP_W-1:0] FILTER_STEP_RESET  = STEP_W'(128);
  localparam logic [THR_W-1:0]  ACTIVITY_THR_RESET = THR_W'(256);
  localparam logic [CNT_W-1:0]  MAX_STEPS_RESET    = CNT_W'(5);
  localparam logic [CNT_W-1:0]  CONFIRM_RESET      = CNT_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_STEP  = 2'd0,
    REG_ACTIVITY_THR = 2'd1,
    REG_MAX_STEPS    = 2'd2,
    REG_CONFIRM      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

  typedef enum logic {
    MODE_QUALIFY = 1'b0,
    MODE_COUNT   = 1'b1
  } mode_e;

endpackage

### sv/dynamic_threshold_step_counter.sv
// ----------------------------------------------------------------------------
// dynamic_threshold_step_counter
// Three-axis step counter with step filters, per-window peak and valley
// tracking, midpoint crossing counts and a walking confirmation stage.
// ----------------------------------------------------------------------------
// The block takes one sample transaction per clock unless the input side
// stalls. A sample goes into an input register; as it leaves that register
// the filter, crossing, extreme and window-end logic update the axis state,
// and a window-end sample writes one result into the output register. Other
// samples give no result. The input side stalls only when a window-end sample
// is waiting and the output register still holds a result not yet taken.
// Configuration writes are always accepted and take effect at once.
module dynamic_threshold_step_counter (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic signed [dtsc_pkg::SAMPLE_BITS-1:0]   accel_x_i,
  input  logic signed [dtsc_pkg::SAMPLE_BITS-1:0]   accel_y_i,
  input  logic signed [dtsc_pkg::SAMPLE_BITS-1:0]   accel_z_i,
  input  logic                                      window_end_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [dtsc_pkg::CNT_W-1:0]                window_crossings_o,
  output logic [1:0]                                dominant_axis_o,
  output logic [dtsc_pkg::CNT_W-1:0]                steps_added_o,
  output logic [dtsc_pkg::TOTAL_BITS-1:0]           total_steps_o,
  output logic                                      counting_mode_o,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [dtsc_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [dtsc_pkg::CFG_DATA_W-1:0]           cfg_data_i
);

  localparam int EW = dtsc_pkg::EXT_W;
  localparam int SW = dtsc_pkg::SAMPLE_BITS;
  localparam int N  = dtsc_pkg::NAXES;
  localparam int CW = dtsc_pkg::CNT_W;
  localparam int CMP_W_L = dtsc_pkg::CMP_W;

  // configuration
  logic [dtsc_pkg::STEP_W-1:0] filter_step_q;
  logic [dtsc_pkg::THR_W-1:0]  activity_thr_q;
  logic [CW-1:0]               max_steps_q;
  logic [CW-1:0]               confirm_q;

  // input register
  logic                        in_valid_q;
  logic signed [SW-1:0]        sample_q [N];
  logic                        window_end_q;
  logic                        advance;

  // axis state
  logic signed [EW-1:0] wmax_q [N];
  logic signed [EW-1:0] wmin_q [N];
  logic signed [EW-1:0] pmax_q [N];
  logic signed [EW-1:0] pmin_q [N];
  logic signed [SW-1:0] filt_q [N];
  logic [CW-1:0]        cross_q [N];

  logic signed [EW-1:0] wmax_d [N];
  logic signed [EW-1:0] wmin_d [N];
  logic signed [SW-1:0] filt_d [N];
  logic [CW-1:0]        cross_d [N];
  logic [EW:0]          swing [N];

  logic [CW-1:0]                    pending_q, pending_d;
  dtsc_pkg::mode_e                  mode_q, mode_d;
  logic [dtsc_pkg::TOTAL_BITS-1:0]  total_q, total_d;

  dtsc_pkg::axis_e   axis;
  logic [CW-1:0]     count;
  logic [CW-1:0]     added;
  logic              plausible;
  logic [CW:0]       pending_sum;
  logic [CW-1:0]     pending_sat;

  // output register
  logic                               out_valid_q;
  logic [CW-1:0]                      crossings_q;
  dtsc_pkg::axis_e                    axis_q;
  logic [CW-1:0]                      added_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_step_q  <= dtsc_pkg::FILTER_STEP_RESET;
      activity_thr_q <= dtsc_pkg::ACTIVITY_THR_RESET;
      max_steps_q    <= dtsc_pkg::MAX_STEPS_RESET;
      confirm_q      <= dtsc_pkg::CONFIRM_RESET;
    end else if (cfg_valid_i) begin
      case (dtsc_pkg::cfg_reg_e'(cfg_index_i))
        dtsc_pkg::REG_FILTER_STEP:  filter_step_q  <= cfg_data_i[dtsc_pkg::STEP_W-1:0];
        dtsc_pkg::REG_ACTIVITY_THR: activity_thr_q <= cfg_data_i[dtsc_pkg::THR_W-1:0];
        dtsc_pkg::REG_MAX_STEPS:    max_steps_q    <= cfg_data_i[CW-1:0];
        dtsc_pkg::REG_CONFIRM:      confirm_q      <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // a sample without window end never produces a result, so it never waits
  assign advance    = in_valid_q && (!window_end_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sample_q[0]  <= accel_x_i;
      sample_q[1]  <= accel_y_i;
      sample_q[2]  <= accel_z_i;
      window_end_q <= window_end_i;
    end
  end

  // per-axis filter, crossing and extreme update
  always_comb begin
    logic signed [EW-1:0] s_ext;
    logic signed [SW:0]   diff;
    logic [CMP_W_L-1:0]   diff_abs;
    logic signed [EW+1:0] mid2;
    logic signed [EW+1:0] before2;
    logic signed [EW+1:0] after2;
    logic signed [EW:0]   sw_diff;
    for (int i = 0; i < N; i++) begin
      s_ext    = EW'(sample_q[i]);
      diff     = (SW+1)'(sample_q[i]) - (SW+1)'(filt_q[i]);
      diff_abs = diff[SW] ? CMP_W_L'(-diff) : CMP_W_L'(diff);
      if (diff_abs > CMP_W_L'(filter_step_q)) begin
        filt_d[i] = sample_q[i];
      end else begin
        filt_d[i] = filt_q[i];
      end
      mid2    = (EW+2)'(pmax_q[i]) + (EW+2)'(pmin_q[i]);
      before2 = $signed({(EW+1)'(filt_q[i]), 1'b0});
      after2  = $signed({(EW+1)'(filt_d[i]), 1'b0});
      if (before2 > mid2 && after2 < mid2 && cross_q[i] != dtsc_pkg::CNT_MAX) begin
        cross_d[i] = cross_q[i] + CW'(1);
      end else begin
        cross_d[i] = cross_q[i];
      end
      wmax_d[i] = (s_ext > wmax_q[i]) ? s_ext : wmax_q[i];
      wmin_d[i] = (s_ext < wmin_q[i]) ? s_ext : wmin_q[i];
      sw_diff   = (EW+1)'(wmax_d[i]) - (EW+1)'(wmin_d[i]);
      swing[i]  = sw_diff[EW] ? (EW+1)'(-sw_diff) : (EW+1)'(sw_diff);
    end
  end

  // most active axis and its crossing count
  always_comb begin
    axis  = dtsc_pkg::AXIS_NONE;
    count = '0;
    if (swing[0] > swing[1] && swing[0] > swing[2] &&
        swing[0] >= (EW+1)'(activity_thr_q)) begin
      axis  = dtsc_pkg::AXIS_X;
      count = cross_d[0];
    end else if (swing[1] > swing[0] && swing[1] > swing[2] &&
                 swing[1] >= (EW+1)'(activity_thr_q)) begin
      axis  = dtsc_pkg::AXIS_Y;
      count = cross_d[1];
    end else if (swing[2] > swing[0] && swing[2] > swing[1] &&
                 swing[2] >= (EW+1)'({activity_thr_q, 1'b0})) begin
      axis  = dtsc_pkg::AXIS_Z;
      count = cross_d[2];
    end
  end

  assign plausible   = (count != '0) && (count <= max_steps_q);
  assign pending_sum = (CW+1)'(pending_q) + (CW+1)'(count);
  assign pending_sat = pending_sum[CW] ? dtsc_pkg::CNT_MAX : pending_sum[CW-1:0];

  // confirmation: next mode
  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      dtsc_pkg::MODE_QUALIFY: begin
        if (plausible && pending_sat >= confirm_q) begin
          mode_d = dtsc_pkg::MODE_COUNT;
        end
      end
      dtsc_pkg::MODE_COUNT: begin
        if (!plausible) begin
          mode_d = dtsc_pkg::MODE_QUALIFY;
        end
      end
      default: mode_d = dtsc_pkg::MODE_QUALIFY;
    endcase
  end

  // confirmation: pending and added steps
  always_comb begin
    pending_d = pending_q;
    added     = '0;
    case (mode_q)
      dtsc_pkg::MODE_QUALIFY: begin
        if (plausible) begin
          if (pending_sat >= confirm_q) begin
            added     = pending_sat;
            pending_d = '0;
          end else begin
            pending_d = pending_sat;
          end
        end else begin
          pending_d = '0;
        end
      end
      dtsc_pkg::MODE_COUNT: begin
        if (plausible) begin
          added = count;
        end
      end
      default: pending_d = '0;
    endcase
  end

  assign total_d = total_q + dtsc_pkg::TOTAL_BITS'(added);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        wmax_q[i]  <= dtsc_pkg::PEAK_RESET;
        wmin_q[i]  <= dtsc_pkg::VALLEY_RESET;
        pmax_q[i]  <= '0;
        pmin_q[i]  <= '0;
        filt_q[i]  <= '0;
        cross_q[i] <= '0;
      end
      pending_q <= '0;
      mode_q    <= dtsc_pkg::MODE_QUALIFY;
      total_q   <= '0;
    end else if (advance) begin
      for (int i = 0; i < N; i++) begin
        filt_q[i] <= filt_d[i];
        if (window_end_q) begin
          pmax_q[i]  <= wmax_d[i];
          pmin_q[i]  <= wmin_d[i];
          wmax_q[i]  <= dtsc_pkg::PEAK_RESET;
          wmin_q[i]  <= dtsc_pkg::VALLEY_RESET;
          cross_q[i] <= '0;
        end else begin
          wmax_q[i]  <= wmax_d[i];
          wmin_q[i]  <= wmin_d[i];
          cross_q[i] <= cross_d[i];
        end
      end
      if (window_end_q) begin
        pending_q <= pending_d;
        mode_q    <= mode_d;
        total_q   <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && window_end_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && window_end_q) begin
      crossings_q <= count;
      axis_q      <= axis;
      added_q     <= added;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign window_crossings_o = crossings_q;
  assign dominant_axis_o    = axis_q;
  assign steps_added_o      = added_q;
  assign total_steps_o      = total_q;
  assign counting_mode_o    = (mode_q == dtsc_pkg::MODE_COUNT);

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dynamic threshold step counter: sample
// transactions are predicted by an in-bench model of the filters, window
// extremes, crossing counters and walking confirmation, and every window
// report is checked field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = dtsc_pkg::SAMPLE_BITS;
  localparam int EW = dtsc_pkg::EXT_W;
  localparam int CW = dtsc_pkg::CNT_W;
  localparam int TW = dtsc_pkg::TOTAL_BITS;
  localparam int DW = dtsc_pkg::CFG_DATA_W;
  localparam int NA = dtsc_pkg::NAXES;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [CW-1:0]     crossings;
    dtsc_pkg::axis_e   axis;
    logic [CW-1:0]     added;
    logic [TW-1:0]     total;
    dtsc_pkg::mode_e   mode;
  } window_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SB-1:0]          accel_x = '0;
  logic signed [SB-1:0]          accel_y = '0;
  logic signed [SB-1:0]          accel_z = '0;
  logic                          window_end = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [CW-1:0]                 window_crossings;
  logic [1:0]                    dominant_axis;
  logic [CW-1:0]                 steps_added;
  logic [TW-1:0]                 total_steps;
  logic                          counting_mode;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dtsc_pkg::CFG_IDX_W-1:0] cfg_index = dtsc_pkg::REG_FILTER_STEP;
  logic [DW-1:0]                 cfg_data = '0;

  // model state
  logic signed [EW-1:0]          peak_q [NA];
  logic signed [EW-1:0]          valley_q [NA];
  logic signed [EW-1:0]          last_peak_q [NA];
  logic signed [EW-1:0]          last_valley_q [NA];
  logic signed [SB-1:0]          smooth_q [NA];
  logic [CW-1:0]                 cross_q [NA];
  logic [CW-1:0]                 pending_q;
  dtsc_pkg::mode_e               mode_q;
  logic [TW-1:0]                 total_q;

  logic [dtsc_pkg::STEP_W-1:0] step_cfg;
  logic [dtsc_pkg::THR_W-1:0]  activity_cfg;
  logic [CW-1:0]               max_steps_cfg;
  logic [CW-1:0]               confirm_cfg;

  window_report_t window_reports [$];

  int  errors = 0;
  int  samples_sent = 0;
  int  reports_checked = 0;
  int  counting_reports = 0;
  int  reg_writes = 0;
  int  long_stalls = 0;
  int  idle_cycles = 0;
  bit  fast_in = 1'b0;
  bit  fast_out = 1'b0;
  bit  rx_hold_req = 1'b0;

  dynamic_threshold_step_counter i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .accel_x_i          (accel_x),
    .accel_y_i          (accel_y),
    .accel_z_i          (accel_z),
    .window_end_i       (window_end),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .window_crossings_o (window_crossings),
    .dominant_axis_o    (dominant_axis),
    .steps_added_o      (steps_added),
    .total_steps_o      (total_steps),
    .counting_mode_o    (counting_mode),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void clear_window();
    int a;
    for (a = 0; a < NA; a++) begin
      peak_q[a]   = dtsc_pkg::PEAK_RESET;
      valley_q[a] = dtsc_pkg::VALLEY_RESET;
      cross_q[a]  = '0;
    end
  endfunction

  function automatic void reset_model();
    int a;
    clear_window();
    for (a = 0; a < NA; a++) begin
      last_peak_q[a]   = '0;
      last_valley_q[a] = '0;
      smooth_q[a]      = '0;
    end
    pending_q     = '0;
    mode_q        = dtsc_pkg::MODE_QUALIFY;
    total_q       = '0;
    step_cfg      = dtsc_pkg::FILTER_STEP_RESET;
    activity_cfg  = dtsc_pkg::ACTIVITY_THR_RESET;
    max_steps_cfg = dtsc_pkg::MAX_STEPS_RESET;
    confirm_cfg   = dtsc_pkg::CONFIRM_RESET;
  endfunction

  function automatic void track_sample(input logic signed [SB-1:0] x, y, z,
                                       input logic last);
    int             s [NA];
    int             sw [NA];
    int             a, prev, mid2, diff, pick, cnt, pend, thr;
    bit             plausible;
    logic [CW-1:0]  added;
    window_report_t rep;
    s[0] = x;
    s[1] = y;
    s[2] = z;
    for (a = 0; a < NA; a++) begin
      prev = smooth_q[a];
      mid2 = int'(last_peak_q[a]) + int'(last_valley_q[a]);
      diff = s[a] - prev;
      if (diff < 0) diff = -diff;
      if (diff > int'(step_cfg)) smooth_q[a] = SB'(s[a]);
      if (2 * prev > mid2 && 2 * int'(smooth_q[a]) < mid2 &&
          cross_q[a] != dtsc_pkg::CNT_MAX)
        cross_q[a]++;
      if (s[a] > peak_q[a]) peak_q[a] = EW'(s[a]);
      if (s[a] < valley_q[a]) valley_q[a] = EW'(s[a]);
    end
    if (!last) return;

    for (a = 0; a < NA; a++) begin
      sw[a] = int'(peak_q[a]) - int'(valley_q[a]);
      if (sw[a] < 0) sw[a] = -sw[a];
    end
    thr = int'(activity_cfg);
    pick = 0;
    if (sw[0] > sw[1] && sw[0] > sw[2] && sw[0] >= thr) pick = 1;
    else if (sw[1] > sw[0] && sw[1] > sw[2] && sw[1] >= thr) pick = 2;
    else if (sw[2] > sw[0] && sw[2] > sw[1] && sw[2] >= 2 * thr) pick = 3;
    cnt = (pick == 0) ? 0 : int'(cross_q[pick-1]);
    plausible = (cnt > 0) && (cnt <= int'(max_steps_cfg));

    added = '0;
    if (mode_q == dtsc_pkg::MODE_QUALIFY) begin
      if (plausible) begin
        pend = int'(pending_q) + cnt;
        if (pend > 255) pend = 255;
        pending_q = CW'(pend);
        if (pending_q >= confirm_cfg) begin
          added     = pending_q;
          pending_q = '0;
          mode_q    = dtsc_pkg::MODE_COUNT;
        end
      end else begin
        pending_q = '0;
      end
    end else if (plausible) begin
      added = CW'(cnt);
    end else begin
      mode_q = dtsc_pkg::MODE_QUALIFY;
    end
    total_q = total_q + TW'(added);

    for (a = 0; a < NA; a++) begin
      last_peak_q[a]   = peak_q[a];
      last_valley_q[a] = valley_q[a];
    end
    clear_window();

    rep.crossings = CW'(cnt);
    rep.axis      = dtsc_pkg::axis_e'(pick);
    rep.added     = added;
    rep.total     = total_q;
    rep.mode      = mode_q;
    window_reports.push_back(rep);
  endfunction

  task automatic send_sample(input int x, y, z, input logic last);
    int gap;
    gap = fast_in ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    accel_x    <= SB'(x);
    accel_y    <= SB'(y);
    accel_z    <= SB'(z);
    window_end <= last;
    do @(posedge clk); while (!in_ready);
    track_sample(SB'(x), SB'(y), SB'(z), last);
    samples_sent++;
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (window_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input dtsc_pkg::cfg_reg_e idx, input int data);
    logic [DW-1:0] bits;
    bits = DW'(data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bits;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dtsc_pkg::REG_FILTER_STEP:  step_cfg      = bits[dtsc_pkg::STEP_W-1:0];
      dtsc_pkg::REG_ACTIVITY_THR: activity_cfg  = bits[dtsc_pkg::THR_W-1:0];
      dtsc_pkg::REG_MAX_STEPS:    max_steps_cfg = bits[CW-1:0];
      dtsc_pkg::REG_CONFIRM:      confirm_cfg   = bits[CW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input int step, thr, max_steps, confirm);
    drain_reports();
    write_register(dtsc_pkg::REG_FILTER_STEP, step);
    write_register(dtsc_pkg::REG_ACTIVITY_THR, thr);
    write_register(dtsc_pkg::REG_MAX_STEPS, max_steps);
    write_register(dtsc_pkg::REG_CONFIRM, confirm);
  endtask

  // square wave on one axis, high half then low half in each period; zero periods sends four flat samples
  task automatic send_walk_window(input int axis, periods, amp, half, center);
    int n, i, a, level;
    int v [NA];
    n = (periods == 0) ? 4 : periods * 2 * half;
    for (i = 0; i < n; i++) begin
      for (a = 0; a < NA; a++) v[a] = int'($urandom_range(0, 80)) - 40;
      if (periods == 0) level = center;
      else if ((i % (2 * half)) >= half) level = center - amp;
      else level = center + amp;
      v[axis-1] = v[axis-1] + level;
      send_sample(v[0], v[1], v[2], i == n - 1);
    end
  endtask

  task automatic send_walk_burst(input int n_windows, amp_lo, amp_hi);
    int axis, center, amp, half, w, r, periods;
    axis     = $urandom_range(1, 3);
    center   = int'($urandom_range(0, 16000)) - 8000;
    amp      = $urandom_range(amp_lo, amp_hi);
    half     = $urandom_range(1, 3);
    fast_in  = ($urandom_range(0, 3) == 0);
    fast_out = ($urandom_range(0, 3) == 0);
    for (w = 0; w < n_windows; w++) begin
      r = $urandom_range(0, 9);
      if (r == 0) periods = 0;
      else if (r == 1) periods = $urandom_range(6, 12);
      else periods = $urandom_range(1, 5);
      send_walk_window(axis, periods, amp, half, center);
    end
  endtask

  task automatic send_noise_window(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_sample($urandom(), $urandom(), $urandom(), i == n - 1 || $urandom_range(0, 7) == 0);
  endtask

  task automatic test_directed_extremes();
    send_sample(0, 0, 0, 1'b1);
    send_sample(32767, -32768, 0, 1'b0);
    send_sample(-32768, 32767, -1, 1'b1);
    send_sample(2000, 0, 0, 1'b0);
    send_sample(-2000, 0, 0, 1'b0);
    send_sample(2000, 0, 0, 1'b0);
    send_sample(-2000, 20, -20, 1'b1);
    send_sample(0, 3000, 0, 1'b0);
    send_sample(0, -3000, 0, 1'b0);
    send_sample(0, 3000, 0, 1'b1);
    // z swing one short of doubled threshold, then exactly on it
    send_sample(0, 0, -255, 1'b0);
    send_sample(0, 0, 256, 1'b1);
    send_sample(0, 0, -256, 1'b0);
    send_sample(0, 0, 256, 1'b1);
    send_sample(0, 0, 0, 1'b0);
    send_sample(256, 0, 0, 1'b1);
    // change equal to filter step does not move the filter
    send_sample(384, 0, 0, 1'b1);
    send_sample(-1, -1, -1, 1'b1);
  endtask

  task automatic test_register_extremes();
    load_settings(0, 0, 255, 1);
    send_walk_burst(4, 300, 4000);
    load_settings(32767, 16383, 1, 255);
    send_walk_burst(4, 8500, 17000);
    load_settings(0, 1, 0, 0);
    send_walk_burst(4, 300, 4000);
    load_settings(128, 256, 1, 0);
    send_walk_burst(4, 300, 4000);
  endtask

  task automatic test_walking();
    while (samples_sent < 600) begin
      load_settings($urandom_range(0, 400), $urandom_range(0, 3000),
                    $urandom_range(1, 8), $urandom_range(1, 20));
      repeat (3) send_walk_burst($urandom_range(3, 8), 300, 4000);
    end
  endtask

  task automatic test_noise_and_broken();
    load_settings($urandom_range(0, 32767), $urandom_range(0, 16383),
                  $urandom_range(0, 255), $urandom_range(0, 255));
    fast_in  = 1'b0;
    fast_out = 1'b0;
    repeat (6) send_noise_window($urandom_range(5, 25));
    load_settings(64, 256, 5, 4);
    send_walk_burst(5, 1000, 3000);
    send_noise_window(8);
    send_walk_burst(4, 1000, 3000);
  endtask

  task automatic test_output_backpressure();
    fast_in     = 1'b1;
    rx_hold_req = 1'b1;
    repeat (24) send_sample($urandom(), $urandom(), $urandom(), 1'b1);
    fast_in = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        stall       = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
        long_stalls++;
      end else begin
        stall = fast_out ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : report_check
    window_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (window_reports.size() == 0) begin
        report_error("window report with none expected");
      end else begin
        want = window_reports.pop_front();
        if (window_crossings !== want.crossings)
          report_error($sformatf("crossings got %0d want %0d", window_crossings, want.crossings));
        if (dominant_axis !== want.axis)
          report_error($sformatf("axis got %0d want %0d", dominant_axis, want.axis));
        if (steps_added !== want.added)
          report_error($sformatf("steps added got %0d want %0d", steps_added, want.added));
        if (total_steps !== want.total)
          report_error($sformatf("total got %0d want %0d", total_steps, want.total));
        if (counting_mode !== want.mode)
          report_error($sformatf("mode got %0d want %0d", counting_mode, want.mode));
        reports_checked++;
        if (counting_mode === 1'b1) counting_reports++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_register_extremes();
    test_walking();
    test_noise_and_broken();
    test_output_backpressure();

    fast_in  = 1'b0;
    fast_out = 1'b0;
    drain_reports();
    if (window_reports.size() != 0)
      report_error($sformatf("%0d window reports never arrived", window_reports.size()));

    $display("covered %0d samples, %0d window reports (%0d in counting mode)",
             samples_sent, reports_checked, counting_reports);
    $display("with %0d register writes and %0d long output stalls", reg_writes, long_stalls);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
sv/dtsc_pkg.sv
sv/dynamic_threshold_step_counter.sv
verif/tb.sv
